// File: rtl/core/olim_pkg.sv
package olim_pkg;

    // Fixed widths of the result fields.
    localparam int ACTIVE_W   = 6;
    localparam int ACTION_W   = 3;
    localparam int STAG_W     = 8;
    localparam int PEND_W     = 5;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = ACTION_W;

    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX      = 6'd63;
    localparam logic [ACTIVE_W-1:0] MAX_ACTIVE_INIT = 6'd6;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_PASS    = 3'd0;
    localparam action_t ACT_START   = 3'd1;
    localparam action_t ACT_QUEUE   = 3'd2;
    localparam action_t ACT_DROP    = 3'd3;
    localparam action_t ACT_REMOVED = 3'd4;
    localparam action_t ACT_FREED   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic new_req;
        logic search;
        logic free;
        logic head;
        logic shift;
        logic out_load;
    } olim_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_kind;
        logic found;
        logic search_end;
        logic dispatch;
        logic shift_end;
        logic out_free;
    } olim_sts_t;

endpackage

// File: rtl/core/olim_ram.sv
module olim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/olim_ctrl.sv
module olim_ctrl
    import olim_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  olim_sts_t sts,
    output olim_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_NEW    = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_FREE   = 7'b0001000,
        S_HEAD   = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = sts.in_kind ? S_SEARCH : S_NEW;
                end
            end
            S_NEW:
            begin
                cmd.new_req = 1'b1;
                state_next  = S_DONE;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.found)
                begin
                    state_next = S_SHIFT;
                end
                else if (sts.search_end)
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.free   = 1'b1;
                state_next = sts.dispatch ? S_HEAD : S_DONE;
            end
            S_HEAD:
            begin
                cmd.head   = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: rtl/core/olim_datapath.sv
module olim_datapath
    import olim_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8,
    parameter int IN_DATA_W   = ((TAG_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [ACTIVE_W-1:0]   cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    input  olim_cmd_t             cmd,
    output olim_sts_t             sts
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PAD_W = OUT_DATA_W - PEND_W - ACTIVE_W - STAG_W - 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic [ACTIVE_W-1:0]   max_reg;
    logic [ACTIVE_W-1:0]   active_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         ptr_reg;
    logic                  vld_reg;
    logic                  m_valid_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic                  sec_reg;
    logic                  byp_reg;
    action_t               action_reg;
    logic                  stv_reg;
    logic [TAG_BITS-1:0]   stag_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    action_t               m_tuser_reg;

    logic [ACTIVE_W-1:0]   act_inc;
    logic [ACTIVE_W-1:0]   act_dec;
    logic                  can_start;
    logic                  q_full;
    logic                  match;
    logic                  ptr_below;
    logic [CW-1:0]         ptr_m2;
    logic [TAG_BITS-1:0]   rd_data;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [TAG_BITS-1:0]   ram_wdata;

    assign act_inc   = (active_reg == ACTIVE_MAX) ? active_reg : active_reg + 6'd1;
    assign act_dec   = (active_reg == '0) ? active_reg : active_reg - 6'd1;
    assign can_start = byp_reg || (active_reg < max_reg);
    assign q_full    = (count_reg == DEPTH_C);
    // The RAM output belongs to position ptr_reg - 1 whenever vld_reg is set.
    assign match     = vld_reg && (rd_data == tag_reg);
    assign ptr_below = (ptr_reg < count_reg);
    assign ptr_m2    = ptr_reg - TWO_C;

    assign sts.in_kind    = s_tuser[0];
    assign sts.found      = match;
    assign sts.search_end = !match && (ptr_reg == count_reg);
    assign sts.dispatch   = (count_reg != '0) && (act_dec < max_reg);
    assign sts.shift_end  = !ptr_below && !vld_reg;
    assign sts.out_free   = !m_valid_reg || m_tready;

    // Compaction reads entry k+1 and writes it to k in the following cycle, one entry per cycle.
    assign ram_re    = cmd.free || (((cmd.search && !match) || cmd.shift) && ptr_below);
    assign ram_raddr = cmd.free ? '0 : ptr_reg[AW-1:0];
    assign ram_we    = (cmd.new_req && sec_reg && !can_start && !q_full)
                    || (cmd.shift && vld_reg);
    assign ram_waddr = cmd.shift ? ptr_m2[AW-1:0] : count_reg[AW-1:0];
    assign ram_wdata = cmd.shift ? rd_data : tag_reg;

    olim_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_pending (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= MAX_ACTIVE_INIT;
            active_reg  <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                max_reg <= cfg_wdata;
            end
            if (cmd.take)
            begin
                ptr_reg <= '0;
                vld_reg <= 1'b0;
            end
            if (cmd.new_req && sec_reg)
            begin
                if (can_start)
                begin
                    active_reg <= act_inc;
                end
                else if (!q_full)
                begin
                    count_reg <= count_reg + ONE_C;
                end
            end
            if (cmd.search)
            begin
                if (match)
                begin
                    vld_reg <= 1'b0;
                end
                else if (ptr_below)
                begin
                    ptr_reg <= ptr_reg + ONE_C;
                    vld_reg <= 1'b1;
                end
            end
            if (cmd.free)
            begin
                active_reg <= act_dec;
            end
            if (cmd.head)
            begin
                active_reg <= act_inc;
                ptr_reg    <= ONE_C;
                vld_reg    <= 1'b0;
            end
            if (cmd.shift)
            begin
                if (ptr_below)
                begin
                    ptr_reg <= ptr_reg + ONE_C;
                    vld_reg <= 1'b1;
                end
                else
                begin
                    vld_reg <= 1'b0;
                    if (!vld_reg)
                    begin
                        count_reg <= count_reg - ONE_C;
                    end
                end
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            tag_reg  <= s_tdata[TAG_BITS-1:0];
            sec_reg  <= s_tuser[1];
            byp_reg  <= s_tuser[2];
            stv_reg  <= 1'b0;
            stag_reg <= '0;
        end
        if (cmd.new_req)
        begin
            if (!sec_reg)
            begin
                action_reg <= ACT_PASS;
            end
            else if (can_start)
            begin
                action_reg <= ACT_START;
                stv_reg    <= 1'b1;
                stag_reg   <= tag_reg;
            end
            else if (!q_full)
            begin
                action_reg <= ACT_QUEUE;
            end
            else
            begin
                action_reg <= ACT_DROP;
            end
        end
        if (cmd.search && match)
        begin
            action_reg <= ACT_REMOVED;
        end
        if (cmd.free)
        begin
            action_reg <= ACT_FREED;
        end
        if (cmd.head)
        begin
            stv_reg  <= 1'b1;
            stag_reg <= rd_data;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, PEND_W'(count_reg), active_reg,
                            STAG_W'(stag_reg), stv_reg};
            m_tuser_reg <= action_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/core/outstanding_request_limiter.sv
// A new request passes through S_NEW to S_DONE, which registers its result word
// once the output is free. A finish event searches the pending tags in turn, and
// the FIFO is compacted entry by entry after a removal or dispatch. One word is
// worked on at a time. Reset (rst_n low, asynchronous) clears the active and
// pending counts and sets the cap to 6; the pending tag RAM is not cleared.
module outstanding_request_limiter
    import olim_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [ACTIVE_W-1:0]                  cfg_wdata,   // max_active
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((TAG_BITS + 7) / 8) * 8-1:0]  s_tdata,     // request_tag
    input  logic [IN_USER_W-1:0]                 s_tuser,     // kind, is_secure, is_bypass
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // started_valid, started_tag, active_now, pending_now
    output logic [OUT_DATA_W-1:0]                m_tdata,
    output logic [OUT_USER_W-1:0]                m_tuser      // action
);

    localparam int IN_DATA_W = ((TAG_BITS + 7) / 8) * 8;

    olim_cmd_t cmd;
    olim_sts_t sts;

    olim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    olim_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .IN_DATA_W   (IN_DATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef NO_ASSERTIONS
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.new_req, cmd.search, cmd.free, cmd.head, cmd.shift,
                  cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    a_head_after_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head |-> $past(cmd.free))
        else $error("head capture without a preceding free");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while another is in progress");

    a_start_action: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == ACT_START || m_tuser == ACT_FREED))
        else $error("started flag with an action that cannot start a request");
`endif

endmodule
